// ===== src/salloc_pkg.sv =====
// Shared types, codes and widths for the stack allocator.
`default_nettype none
package salloc_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 24;
  localparam int unsigned ALIGN_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MARKER_DEPTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_ALLOC       = 3'd0,
    OP_ALLOC_ALIGN = 3'd1,
    OP_FREE        = 3'd2,
    OP_FREE_ALIGN  = 3'd3,
    OP_SAVE        = 3'd4,
    OP_RESTORE     = 3'd5,
    OP_CLEAR       = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_SPILL      = 2'd1,
    STAT_STACK_FULL = 2'd2,
    STAT_NO_MARKER  = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BUFFER_BASE = 1'd0,
    REG_CAPACITY    = 1'd1
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;      // execute the accepted word and load the result
    logic pop_req;   // start a marker pop: read the stack, drop the count
    logic pop_load;  // finish the pop: take the read data as the offset
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pop_ok;    // the word on the input is a restore with a marker saved
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/salloc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module salloc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/salloc_ctrl.sv =====
// Controller: handshake, result-valid flag and the two-step marker pop.
`default_nettype none
module salloc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire salloc_pkg::dp_stat_t dp_stat,
  output salloc_pkg::ctl_cmd_t     cmd
);

  salloc_pkg::state_t state, state_next;
  logic accept;
  logic out_valid_next;

  assign in_ready = (state == salloc_pkg::ST_IDLE) && (!out_valid || out_ready);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      salloc_pkg::ST_IDLE: begin
        if (accept && dp_stat.pop_ok) begin
          state_next = salloc_pkg::ST_POP;
        end
      end
      salloc_pkg::ST_POP: begin
        state_next = salloc_pkg::ST_IDLE;
      end
      default: begin
        state_next = salloc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      salloc_pkg::ST_IDLE: begin
        cmd.exec = accept && !dp_stat.pop_ok;
        cmd.pop_req = accept && dp_stat.pop_ok;
      end
      salloc_pkg::ST_POP: begin
        cmd.pop_load = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // the output register is free whenever a word is accepted, so a load never overwrites
  always_comb begin
    if (cmd.exec || cmd.pop_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= salloc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/salloc_dp.sv =====
// Datapath: config registers, offset, high-water mark, marker stack and result register.
`default_nettype none
module salloc_dp #(
  parameter int unsigned MARKER_DEPTH = salloc_pkg::MARKER_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [salloc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [salloc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [2:0]                          op,
  input  wire logic [salloc_pkg::SIZE_W-1:0]       request_size,
  input  wire logic [salloc_pkg::ALIGN_W-1:0]      alignment,
  input  wire logic [salloc_pkg::ADDR_W-1:0]       address,
  input  wire logic [salloc_pkg::ALIGN_W-1:0]      adjust_in,
  input  wire salloc_pkg::ctl_cmd_t                cmd,
  output salloc_pkg::dp_stat_t                     dp_stat,
  output logic      [salloc_pkg::ADDR_W-1:0]       address_out,
  output logic      [salloc_pkg::ALIGN_W-1:0]      adjust_out,
  output logic      [salloc_pkg::STATUS_W-1:0]     status,
  output logic                                     outside_buffer,
  output logic      [salloc_pkg::SIZE_W-1:0]       current_offset,
  output logic      [salloc_pkg::SIZE_W-1:0]       peak_offset
);

  localparam int unsigned SW = salloc_pkg::SIZE_W;
  localparam int unsigned AW = salloc_pkg::ADDR_W;
  localparam int unsigned GW = salloc_pkg::ALIGN_W;
  localparam int unsigned CNT_W = $clog2(MARKER_DEPTH + 1);
  localparam int unsigned MA_W = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;

  logic [AW-1:0]    buffer_base;
  logic [SW-1:0]    capacity;
  logic [SW-1:0]    offset, offset_next;
  logic [SW-1:0]    high_water, high_water_next;
  logic [CNT_W-1:0] marker_count, marker_count_next;

  logic [AW-1:0]    res_addr;
  logic [GW-1:0]    res_adj;
  salloc_pkg::status_t res_status;
  logic             res_outside;

  salloc_pkg::op_t  op_code;
  logic             stack_full;
  logic             stack_empty;
  logic [SW+1:0]    need;
  logic [SW+1:0]    end_sum;
  logic             fits;
  logic [SW-1:0]    bumped;
  logic [GW-1:0]    raw_low;
  logic [GW-1:0]    align_mask;
  logic [GW-1:0]    adj;
  logic [AW-1:0]    base_ptr;
  logic [AW-1:0]    align_addr;
  logic [AW-1:0]    free_ptr;
  logic [AW:0]      buf_end;
  logic             ptr_outside;

  logic             ram_we;
  logic [MA_W-1:0]  ram_waddr;
  logic [MA_W-1:0]  ram_raddr;
  logic [SW-1:0]    ram_rdata;
  logic [CNT_W-1:0] count_dec;

  assign op_code = salloc_pkg::op_t'(op);
  assign stack_full = (marker_count == CNT_W'(MARKER_DEPTH));
  assign stack_empty = (marker_count == '0);
  assign dp_stat.pop_ok = (op_code == salloc_pkg::OP_RESTORE) && !stack_empty;
  assign count_dec = marker_count - CNT_W'(1);

  // fit test, done wide so it never wraps
  always_comb begin
    if (op_code == salloc_pkg::OP_ALLOC_ALIGN) begin
      need = {2'b00, request_size} + {{(SW + 2 - GW){1'b0}}, alignment};
    end else begin
      need = {2'b00, request_size};
    end
  end
  assign end_sum = {2'b00, offset} + need;
  assign fits = (end_sum <= {2'b00, capacity});
  assign bumped = end_sum[SW-1:0];

  // adjust depends only on the low byte of the raw pointer
  assign raw_low = buffer_base[GW-1:0] + offset[GW-1:0];
  assign align_mask = alignment - GW'(1);
  assign adj = alignment - (raw_low & align_mask);
  assign base_ptr = buffer_base + {{(AW - SW){1'b0}}, offset};
  assign align_addr = buffer_base + {{(AW - SW){1'b0}}, offset}
                      + {{(AW - GW){1'b0}}, adj};

  assign free_ptr = (op_code == salloc_pkg::OP_FREE_ALIGN) ?
                    address - {{(AW - GW){1'b0}}, adjust_in} : address;
  assign buf_end = {1'b0, buffer_base} + {{(AW + 1 - SW){1'b0}}, capacity};
  assign ptr_outside = (free_ptr < buffer_base) || ({1'b0, free_ptr} >= buf_end);

  assign ram_we = cmd.exec && (op_code == salloc_pkg::OP_SAVE) && !stack_full;
  assign ram_waddr = marker_count[MA_W-1:0];
  assign ram_raddr = count_dec[MA_W-1:0];

  salloc_ram #(
    .WIDTH (SW),
    .DEPTH (MARKER_DEPTH)
  ) u_marker_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (offset),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    offset_next = offset;
    high_water_next = high_water;
    marker_count_next = marker_count;
    res_addr = '0;
    res_adj = '0;
    res_status = salloc_pkg::STAT_OK;
    res_outside = 1'b0;
    if (cmd.pop_load) begin
      offset_next = ram_rdata;
    end else if (cmd.pop_req) begin
      marker_count_next = count_dec;
    end else if (cmd.exec) begin
      case (op_code)
        salloc_pkg::OP_ALLOC, salloc_pkg::OP_ALLOC_ALIGN: begin
          if (fits) begin
            offset_next = bumped;
            if (bumped > high_water) begin
              high_water_next = bumped;
            end
            if (op_code == salloc_pkg::OP_ALLOC_ALIGN) begin
              res_addr = align_addr;
              res_adj = adj;
            end else begin
              res_addr = base_ptr;
            end
          end else begin
            res_status = salloc_pkg::STAT_SPILL;
          end
        end
        salloc_pkg::OP_FREE, salloc_pkg::OP_FREE_ALIGN: begin
          res_outside = ptr_outside;
        end
        salloc_pkg::OP_SAVE: begin
          if (stack_full) begin
            res_status = salloc_pkg::STAT_STACK_FULL;
          end else begin
            marker_count_next = marker_count + CNT_W'(1);
          end
        end
        salloc_pkg::OP_RESTORE: begin
          // only the empty case reaches here; a real pop takes the two-step path
          res_status = salloc_pkg::STAT_NO_MARKER;
        end
        salloc_pkg::OP_CLEAR: begin
          offset_next = '0;
          marker_count_next = '0;
        end
        default: begin
          res_status = salloc_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base <= '0;
      capacity <= '0;
      offset <= '0;
      high_water <= '0;
      marker_count <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (salloc_pkg::cfg_reg_t'(cfg_index))
          salloc_pkg::REG_BUFFER_BASE: buffer_base <= cfg_data[AW-1:0];
          salloc_pkg::REG_CAPACITY:    capacity <= cfg_data[SW-1:0];
          default: begin
            capacity <= capacity;
          end
        endcase
      end
      offset <= offset_next;
      high_water <= high_water_next;
      marker_count <= marker_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.pop_load) begin
      address_out <= res_addr;
      adjust_out <= res_adj;
      status <= res_status;
      outside_buffer <= res_outside;
      current_offset <= offset_next;
      peak_offset <= high_water_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/stack_allocator_with_markers.sv =====
// Stack allocator with markers: bump allocation over a configured buffer.
//
// Usage: program buffer_base (index 0) and capacity (index 1) through the
// cfg_wr_en/cfg_index/cfg_data port while idle. Request words enter on
// in_valid/in_ready with op and its operands; each word yields exactly one
// result word on out_valid/out_ready.
// Result timing: out_valid rises in the cycle after acceptance for every op
// except a restore with a saved marker, which passes through ST_POP first
// because the marker stack RAM has a registered read port.
// Throughput: one word per cycle while the receiver keeps up; a restore
// with a saved marker holds in_ready low while the controller is in ST_POP.
// The result register parts the channels: a new word is taken in the same
// cycle the previous result is taken. While the receiver stalls, the result
// holds and in_ready stays low.
// Reset clears base, capacity, offset, high-water mark and marker count;
// marker stack contents need no clearing since only pushed entries are read.
`default_nettype none
module stack_allocator_with_markers #(
  parameter int unsigned MARKER_DEPTH = salloc_pkg::MARKER_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [salloc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [salloc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [2:0]                          op,
  input  wire logic [salloc_pkg::SIZE_W-1:0]       request_size,
  input  wire logic [salloc_pkg::ALIGN_W-1:0]      alignment,
  input  wire logic [salloc_pkg::ADDR_W-1:0]       address,
  input  wire logic [salloc_pkg::ALIGN_W-1:0]      adjust_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [salloc_pkg::ADDR_W-1:0]       address_out,
  output logic      [salloc_pkg::ALIGN_W-1:0]      adjust_out,
  output logic      [salloc_pkg::STATUS_W-1:0]     status,
  output logic                                     outside_buffer,
  output logic      [salloc_pkg::SIZE_W-1:0]       current_offset,
  output logic      [salloc_pkg::SIZE_W-1:0]       peak_offset
);

  salloc_pkg::ctl_cmd_t cmd;
  salloc_pkg::dp_stat_t dp_stat;

  salloc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  salloc_dp #(
    .MARKER_DEPTH (MARKER_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .request_size   (request_size),
    .alignment      (alignment),
    .address        (address),
    .adjust_in      (adjust_in),
    .cmd            (cmd),
    .dp_stat        (dp_stat),
    .address_out    (address_out),
    .adjust_out     (adjust_out),
    .status         (status),
    .outside_buffer (outside_buffer),
    .current_offset (current_offset),
    .peak_offset    (peak_offset)
  );

  // a stalled result blocks new words
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while result stalled");

  // an accepted word either shows its result next cycle or holds the input
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (out_valid || !in_ready))
    else $error("accepted word neither produced a result nor blocked input");

  // a spilled allocation returns no address and no adjust
  a_spill_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == salloc_pkg::STAT_SPILL)) |->
      ((address_out == '0) && (adjust_out == '0)))
    else $error("spilled result carries an address");

  // only a free reports an outside pointer, and a free is always ok
  a_outside_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outside_buffer) |->
      ((status == salloc_pkg::STAT_OK) && (address_out == '0)))
    else $error("outside flag on a non-free result");

endmodule
`default_nettype wire

// ===== tb/salloc_checker.sv =====
// Checker for the stack allocator: predicts each result word and compares it.
module salloc_checker
  import salloc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [2:0]             op,
  input  logic [SIZE_W-1:0]      request_size,
  input  logic [ALIGN_W-1:0]     alignment,
  input  logic [ADDR_W-1:0]      address,
  input  logic [ALIGN_W-1:0]     adjust_in,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [ADDR_W-1:0]      address_out,
  input  logic [ALIGN_W-1:0]     adjust_out,
  input  logic [STATUS_W-1:0]    status,
  input  logic                   outside_buffer,
  input  logic [SIZE_W-1:0]      current_offset,
  input  logic [SIZE_W-1:0]      peak_offset,
  output int unsigned            mismatch_count,
  output int unsigned            results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ADDR_W-1:0]  address_out;
    logic [ALIGN_W-1:0] adjust_out;
    status_t            status;
    logic               outside_buffer;
    logic [SIZE_W-1:0]  current_offset;
    logic [SIZE_W-1:0]  peak_offset;
  } alloc_result_t;

  logic [ADDR_W-1:0] buf_base;
  logic [SIZE_W-1:0] buf_cap;
  logic [SIZE_W-1:0] bump_offset;
  logic [SIZE_W-1:0] high_mark;
  logic [SIZE_W-1:0] saved_offsets [MARKER_DEPTH_DEF];
  int unsigned       saved_count;
  alloc_result_t     results_owed [$];

  // sums taken one bit wider so the buffer end never wraps
  function automatic logic lies_outside(logic [ADDR_W-1:0] ptr);
    return ({1'b0, ptr} < {1'b0, buf_base}) ||
           ({1'b0, ptr} >= {1'b0, buf_base} + {9'd0, buf_cap});
  endfunction

  function automatic alloc_result_t serve_request(logic [2:0] code, logic [SIZE_W-1:0] size,
                                                  logic [ALIGN_W-1:0] align,
                                                  logic [ADDR_W-1:0] ptr,
                                                  logic [ALIGN_W-1:0] adj);
    alloc_result_t r;
    logic [32:0]   need;
    logic [31:0]   raw;
    logic [7:0]    mask;
    r = '0;
    r.status = STAT_OK;
    case (code)
      OP_ALLOC, OP_ALLOC_ALIGN: begin
        need = {9'd0, size};
        if (code == OP_ALLOC_ALIGN) need = need + {25'd0, align};
        if ({9'd0, bump_offset} + need > {9'd0, buf_cap}) begin
          r.status = STAT_SPILL;
        end else begin
          raw = buf_base + {8'd0, bump_offset};
          bump_offset = bump_offset + need[SIZE_W-1:0];
          if (bump_offset > high_mark) high_mark = bump_offset;
          if (code == OP_ALLOC_ALIGN) begin
            // alignment 0 wraps to an all-ones mask
            mask = align - 8'd1;
            r.adjust_out = align - (raw[7:0] & mask);
            r.address_out = raw + {24'd0, r.adjust_out};
          end else begin
            r.address_out = raw;
          end
        end
      end
      OP_FREE:       r.outside_buffer = lies_outside(ptr);
      OP_FREE_ALIGN: r.outside_buffer = lies_outside(ptr - {24'd0, adj});
      OP_SAVE: begin
        if (saved_count >= MARKER_DEPTH_DEF) begin
          r.status = STAT_STACK_FULL;
        end else begin
          saved_offsets[saved_count] = bump_offset;
          saved_count++;
        end
      end
      OP_RESTORE: begin
        if (saved_count == 0) begin
          r.status = STAT_NO_MARKER;
        end else begin
          saved_count--;
          bump_offset = saved_offsets[saved_count];
        end
      end
      OP_CLEAR: begin
        bump_offset = '0;
        saved_count = 0;
      end
      default: ;
    endcase
    r.current_offset = bump_offset;
    r.peak_offset = high_mark;
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    alloc_result_t want;
    if (rst) begin
      buf_base = '0;
      buf_cap = '0;
      bump_offset = '0;
      high_mark = '0;
      saved_count = 0;
      mismatch_count = 0;
      results_owed.delete();
    end else begin
      // check the outgoing word before queuing this edge's request
      if (out_valid && out_ready) begin
        if (results_owed.size() == 0) begin
          $error("result word with nothing expected");
          mismatch_count++;
        end else begin
          want = results_owed.pop_front();
          check_field("address_out", want.address_out, address_out);
          check_field("adjust_out", {24'd0, want.adjust_out}, {24'd0, adjust_out});
          check_field("status", {30'd0, want.status}, {30'd0, status});
          check_field("outside_buffer", {31'd0, want.outside_buffer}, {31'd0, outside_buffer});
          check_field("current_offset", {8'd0, want.current_offset}, {8'd0, current_offset});
          check_field("peak_offset", {8'd0, want.peak_offset}, {8'd0, peak_offset});
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BUFFER_BASE: buf_base = cfg_data;
          REG_CAPACITY:    buf_cap = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        results_owed.push_back(serve_request(op, request_size, alignment, address, adjust_in));
    end
    results_due = results_owed.size();
  end

endmodule

// ===== tb/stack_allocator_with_markers_tb.sv =====
// Testbench top for the stack allocator: stimulus, configuration and verdict.
module stack_allocator_with_markers_tb;
  import salloc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [2:0]             op;
  logic [SIZE_W-1:0]      request_size;
  logic [ALIGN_W-1:0]     alignment;
  logic [ADDR_W-1:0]      address;
  logic [ALIGN_W-1:0]     adjust_in;
  logic                   out_valid;
  logic                   out_ready;
  logic [ADDR_W-1:0]      address_out;
  logic [ALIGN_W-1:0]     adjust_out;
  logic [STATUS_W-1:0]    status;
  logic                   outside_buffer;
  logic [SIZE_W-1:0]      current_offset;
  logic [SIZE_W-1:0]      peak_offset;
  int unsigned            mismatch_count;
  int unsigned            results_due;

  logic [ADDR_W-1:0] cur_base;
  logic [SIZE_W-1:0] cur_cap;
  int unsigned       words_sent;
  bit                calm;
  bit                hold_rx;
  bit                hold_done;

  stack_allocator_with_markers dut (.*);
  salloc_checker chk (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #1ms;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (80) @(negedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic [2:0] code, logic [SIZE_W-1:0] size, logic [ALIGN_W-1:0] align,
                           logic [ADDR_W-1:0] ptr, logic [ALIGN_W-1:0] adj);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    request_size <= size;
    alignment <= align;
    address <= ptr;
    adjust_in <= adj;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (words_sent == 150) hold_rx = 1'b1;
    calm = (words_sent >= 260 && words_sent < 360);
    @(negedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] random_size();
    case ($urandom_range(9))
      0:       return 24'($urandom_range(0, 24'hFFFFFF));
      1:       return cur_cap;
      default: return 24'($urandom_range(0, cur_cap / 16 + 2));
    endcase
  endfunction

  function automatic logic [ALIGN_W-1:0] random_align();
    if ($urandom_range(3) == 0) return 8'($urandom_range(1, 128));
    return 8'(1 << $urandom_range(0, 7));
  endfunction

  // favor the buffer edges, where the inside/outside decision flips
  function automatic logic [ADDR_W-1:0] random_pointer();
    logic [ADDR_W-1:0] p;
    case ($urandom_range(6))
      0:       p = cur_base - 32'd1;
      1:       p = cur_base;
      2:       p = cur_base + {8'd0, cur_cap} - 32'd1;
      3:       p = cur_base + {8'd0, cur_cap};
      4:       p = $urandom;
      default: p = cur_base + $urandom_range(0, cur_cap);
    endcase
    return p;
  endfunction

  task automatic send_op(logic [2:0] code);
    send_word(code, random_size(), random_align(), random_pointer(), 8'($urandom_range(0, 128)));
  endtask

  task automatic configure(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] cap);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_BUFFER_BASE;
    cfg_data <= base;
    @(negedge clk);
    cfg_index <= REG_CAPACITY;
    cfg_data <= {8'd0, cap};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_base = base;
    cur_cap = cap;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (results_due == 0);
    repeat (4) @(negedge clk);
  endtask

  // overflow the marker stack, then pop past empty
  task automatic run_markers_deep();
    int unsigned n;
    n = 32 + $urandom_range(1, 3);
    repeat (n) begin
      if ($urandom_range(3) == 0) send_op(OP_ALLOC);
      send_op(OP_SAVE);
    end
    repeat (n + 1) send_op(OP_RESTORE);
  endtask

  task automatic run_frame();
    int unsigned n;
    n = $urandom_range(1, 6);
    send_op(OP_SAVE);
    repeat (n) begin
      case ($urandom_range(3))
        0:       send_op(OP_ALLOC);
        1:       send_op(OP_ALLOC_ALIGN);
        2:       send_op(OP_FREE);
        default: send_op(OP_FREE_ALIGN);
      endcase
    end
    if ($urandom_range(4) != 0) send_op(OP_RESTORE);
  endtask

  task automatic run_random(int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        run_frame();
      end else if (pick < 65) begin
        send_word(3'($urandom_range(0, 7)), random_size(), random_align(), random_pointer(),
                  8'($urandom_range(0, 255)));
      end else if (pick < 72) begin
        send_op(OP_CLEAR);
      end else if (pick < 85) begin
        // drive toward a spill
        repeat ($urandom_range(3, 8))
          send_word(OP_ALLOC, 24'($urandom_range(0, cur_cap / 3 + 1)), random_align(),
                    random_pointer(), 8'($urandom_range(0, 128)));
      end else if (pick < 88) begin
        run_markers_deep();
      end else begin
        repeat ($urandom_range(1, 3)) send_op(OP_RESTORE);
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] bases [5];
    logic [SIZE_W-1:0] caps [5];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_BUFFER_BASE;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_ALLOC;
    request_size = '0;
    alignment = 8'd1;
    address = '0;
    adjust_in = '0;
    cur_base = '0;
    cur_cap = '0;
    words_sent = 0;
    calm = 1'b0;
    hold_rx = 1'b0;
    hold_done = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    configure(32'h0000_1000, 24'd1024);
    send_word(OP_ALLOC, 24'd0, 8'd1, 32'd0, 8'd0);
    send_word(OP_ALLOC, 24'd100, 8'd1, 32'd0, 8'd0);
    send_word(OP_ALLOC_ALIGN, 24'd10, 8'd128, 32'd0, 8'd0);
    send_word(OP_ALLOC_ALIGN, 24'd5, 8'd1, 32'd0, 8'd0);
    send_word(OP_ALLOC_ALIGN, 24'd3, 8'd0, 32'd0, 8'd0);
    send_word(OP_ALLOC_ALIGN, 24'd7, 8'd3, 32'd0, 8'd0);
    send_word(OP_ALLOC_ALIGN, 24'd0, 8'hFF, 32'd0, 8'd0);
    send_word(OP_ALLOC, 24'hFFFFFF, 8'd1, 32'd0, 8'd0);
    send_word(OP_SAVE, 24'd0, 8'd1, 32'd0, 8'd0);
    send_word(OP_ALLOC, 24'd200, 8'd1, 32'd0, 8'd0);
    send_word(OP_RESTORE, 24'd0, 8'd1, 32'd0, 8'd0);
    send_word(OP_RESTORE, 24'd0, 8'd1, 32'd0, 8'd0);
    send_word(OP_FREE, 24'd0, 8'd1, 32'h0000_0FFF, 8'd0);
    send_word(OP_FREE, 24'd0, 8'd1, 32'h0000_1000, 8'd0);
    send_word(OP_FREE, 24'd0, 8'd1, 32'h0000_13FF, 8'd0);
    send_word(OP_FREE, 24'd0, 8'd1, 32'h0000_1400, 8'd0);
    send_word(OP_FREE, 24'hFFFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_word(OP_FREE_ALIGN, 24'd0, 8'd1, 32'h0000_1010, 8'd128);
    send_word(OP_FREE_ALIGN, 24'd0, 8'd1, 32'h0000_0005, 8'd128);
    send_word(3'd7, 24'hFFFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_word(OP_SAVE, 24'd0, 8'd1, 32'd0, 8'd0);
    send_word(OP_CLEAR, 24'd0, 8'd1, 32'd0, 8'd0);
    send_word(OP_RESTORE, 24'd0, 8'd1, 32'd0, 8'd0);
    send_word(OP_ALLOC, 24'd1024, 8'd1, 32'd0, 8'd0);
    send_word(OP_ALLOC, 24'd0, 8'd1, 32'd0, 8'd0);
    wait_idle();

    // offset carries over, so a lower capacity starts out below it
    bases = '{32'hFFFF_FF80, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h8000_0000};
    caps = '{24'hFFFFFF, 24'd0, 24'd4096, 24'($urandom_range(256, 65536)), 24'h000FFF};
    for (int i = 0; i < 5; i++) begin
      configure(bases[i], caps[i]);
      if (i == 2) run_markers_deep();
      run_random(85);
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
